>>> rtl/tone_table_sequencer_defines.svh
// Assertion macros shared by the sequencer RTL.
// Both sample on clk and are off while rst_n is low.
`ifndef TONE_TABLE_SEQUENCER_DEFINES_SVH
`define TONE_TABLE_SEQUENCER_DEFINES_SVH

// Same-cycle implication.
`define TTS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tts_pkg.sv
package tts_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int FREQ_W     = 16;
    localparam int MS_W       = 16;
    localparam int TEMPO_W    = 16;
    localparam int TIME_W     = 24;
    localparam int COUNT_OUT_W = 7;
    localparam int ENTRY_W    = FREQ_W + MS_W;
    localparam int PROD_W     = MS_W + TEMPO_W;
    localparam int TEMPO_FRAC = 8;

    // iterative multiplier: one tempo digit per cycle
    localparam int DIGIT_W    = 4;
    localparam int MUL_STEPS  = TEMPO_W / DIGIT_W;
    localparam int STEP_CNT_W = $clog2(MUL_STEPS);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [TIME_W-1:0]  ELAPSED_SAT = '1;
    localparam logic [TEMPO_W-1:0] TEMPO_RST   = 16'd256;
    localparam int ZIGZAG_BACK = 2;

    typedef enum logic [1:0] {
        REG_TEMPO  = 2'd0,
        REG_REPEAT = 2'd1,
        REG_ZIGZAG = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_APPEND = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_REWIND = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL
    } state_t;

    typedef struct packed {
        logic [TEMPO_W-1:0] tempo_q8;
        logic               repeat_on;
        logic               zigzag_on;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [MS_W-1:0]    multiplicand;
        logic [TEMPO_W-1:0] multiplier;
    } mul_req_t;

    typedef struct packed {
        logic                   playing;
        logic                   note_start;
        logic [FREQ_W-1:0]      start_freq;
        logic [TIME_W-1:0]      start_ms;
        logic                   silence;
        logic                   table_full;
        logic [COUNT_OUT_W-1:0] stored_count;
    } res_t;

endpackage

>>> rtl/tts_ram.sv
module tts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tts_mul.sv
// Digit-serial multiplier, Horner form: acc = acc*16 + a*digit, MSB digit first.
module tts_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tts_pkg::mul_req_t             req,
    output logic                          done,
    output logic [tts_pkg::PROD_W-1:0]    product
);

    localparam int AW = tts_pkg::MS_W;
    localparam int BW = tts_pkg::TEMPO_W;
    localparam int DW = tts_pkg::DIGIT_W;
    localparam int PW = tts_pkg::PROD_W;

    logic                          run_reg,  run_next;
    logic                          done_reg, done_next;
    logic [tts_pkg::STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]                 a_reg, a_next;
    logic [BW-1:0]                 b_reg, b_next;
    logic [PW-1:0]                 acc_reg, acc_next;
    logic [AW+DW-1:0]              partial;

    assign partial = a_reg * b_reg[BW-1 -: DW];

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            a_next   = req.multiplicand;
            b_next   = req.multiplier;
            acc_next = '0;
        end
        else if (run_reg)
        begin
            acc_next = {acc_reg[PW-DW-1:0], {DW{1'b0}}} + PW'(partial);
            b_next   = {b_reg[BW-DW-1:0], {DW{1'b0}}};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tts_pkg::STEP_CNT_W'(tts_pkg::MUL_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> rtl/tts_core.sv
module tts_core #(
    parameter int TABLE_DEPTH = tts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  operation,
    input  logic [tts_pkg::FREQ_W-1:0]  note_freq,
    input  logic [tts_pkg::MS_W-1:0]    note_ms,
    input  tts_pkg::cfg_t               cfg,
    output logic                        busy,
    output logic                        done,
    output tts_pkg::res_t               res
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = CW + 1;
    localparam int TW = tts_pkg::TIME_W;

    tts_pkg::state_t        state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic signed [PW-1:0]   pos_reg, pos_next;
    logic                   fwd_reg, fwd_next;
    logic [TW-1:0]          elapsed_reg, elapsed_next;
    logic [TW-1:0]          wait_reg, wait_next;
    logic [tts_pkg::FREQ_W-1:0] freq_hold_reg, freq_hold_next;
    tts_pkg::res_t          res_reg, res_next;
    logic                   done_reg, done_next;

    logic                   accept;
    logic                   ram_we;
    logic [tts_pkg::ENTRY_W-1:0] ram_rdata;
    tts_pkg::mul_req_t      mul_req;
    logic                   mul_done;
    logic [tts_pkg::PROD_W-1:0] mul_prod;

    logic [TW-1:0]          elapsed_inc;
    logic                   due;
    logic                   in_range;
    logic signed [PW-1:0]   cnt_s;
    logic signed [PW-1:0]   pos_step;
    logic [TW-1:0]          len;

    assign accept = start && (state_reg == tts_pkg::ST_IDLE);
    assign busy   = (state_reg != tts_pkg::ST_IDLE);

    assign cnt_s       = PW'(count_reg);
    assign elapsed_inc = (elapsed_reg == tts_pkg::ELAPSED_SAT) ? elapsed_reg
                                                               : elapsed_reg + 1'b1;
    assign due         = (elapsed_inc > wait_reg);
    assign in_range    = !pos_reg[PW-1] && (pos_reg < cnt_s);
    assign pos_step    = fwd_reg ? pos_reg + PW'(1) : pos_reg - PW'(1);
    assign len         = mul_prod[tts_pkg::TEMPO_FRAC +: TW];

    assign mul_req.start        = (state_reg == tts_pkg::ST_FETCH);
    assign mul_req.multiplicand = ram_rdata[tts_pkg::ENTRY_W-1 -: tts_pkg::MS_W];
    assign mul_req.multiplier   = cfg.tempo_q8;

    tts_ram #(
        .WIDTH (tts_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({note_ms, note_freq}),
        .re    (accept),
        .raddr (pos_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    tts_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_prod)
    );

    always_comb
    begin
        tts_pkg::res_t r;
        logic          fin;

        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        fwd_next       = fwd_reg;
        elapsed_next   = elapsed_reg;
        wait_next      = wait_reg;
        freq_hold_next = freq_hold_reg;
        ram_we         = 1'b0;
        r              = '0;
        fin            = 1'b0;

        case (state_reg)
            tts_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (tts_pkg::op_t'(operation))
                        tts_pkg::OP_TICK:
                        begin
                            elapsed_next = elapsed_inc;
                            if (!due)
                            begin
                                r.playing = 1'b1;
                                fin       = 1'b1;
                            end
                            else if (!in_range)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                state_next = tts_pkg::ST_FETCH;
                            end
                        end
                        tts_pkg::OP_APPEND:
                        begin
                            if (count_reg < CW'(TABLE_DEPTH))
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                r.table_full = 1'b1;
                            end
                            fin = 1'b1;
                        end
                        tts_pkg::OP_CLEAR:
                        begin
                            count_next   = '0;
                            pos_next     = '0;
                            fwd_next     = 1'b1;
                            elapsed_next = tts_pkg::ELAPSED_SAT;
                            fin          = 1'b1;
                        end
                        tts_pkg::OP_REWIND:
                        begin
                            r.silence = 1'b1;
                            pos_next  = '0;
                            fin       = 1'b1;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            tts_pkg::ST_FETCH:
            begin
                freq_hold_next = ram_rdata[tts_pkg::FREQ_W-1:0];
                state_next     = tts_pkg::ST_MUL;
            end
            tts_pkg::ST_MUL:
            begin
                if (mul_done)
                begin
                    wait_next    = len;
                    elapsed_next = '0;
                    r.playing    = 1'b1;
                    r.note_start = 1'b1;
                    r.start_freq = freq_hold_reg;
                    r.start_ms   = len;
                    fin          = 1'b1;
                    state_next   = tts_pkg::ST_IDLE;
                    // step, then fold back at the table ends when repeating
                    pos_next = pos_step;
                    if (cfg.repeat_on && (pos_step >= cnt_s))
                    begin
                        if (cfg.zigzag_on)
                        begin
                            pos_next = cnt_s - PW'(tts_pkg::ZIGZAG_BACK);
                            fwd_next = !fwd_reg;
                        end
                        else
                        begin
                            pos_next = '0;
                        end
                    end
                    else if (cfg.repeat_on && pos_step[PW-1])
                    begin
                        if (cfg.zigzag_on)
                        begin
                            pos_next = PW'(1);
                            fwd_next = !fwd_reg;
                        end
                        else
                        begin
                            pos_next = cnt_s - PW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = tts_pkg::ST_IDLE;
            end
        endcase

        r.stored_count = tts_pkg::COUNT_OUT_W'(count_next);
        res_next  = fin ? r : res_reg;
        done_next = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tts_pkg::ST_IDLE;
            count_reg   <= '0;
            pos_reg     <= '0;
            fwd_reg     <= 1'b1;
            elapsed_reg <= tts_pkg::ELAPSED_SAT;
            wait_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            fwd_reg     <= fwd_next;
            elapsed_reg <= elapsed_next;
            wait_reg    <= wait_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_hold_reg <= freq_hold_next;
        res_reg       <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

>>> rtl/tone_table_sequencer.sv
// channel   | handshake                     | payload
// ----------+-------------------------------+------------------------------------------
// item in   | start, busy                   | operation, note_freq, note_ms
// result    | done (one-cycle strobe)       | playing, note_start, start_freq, start_ms,
//           |                               | silence, table_full, stored_count
// config    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Append, clear, rewind and ticks that issue nothing: result the cycle after accept, no busy.
// A tick that issues a note reads the table, then runs the 4-step digit-serial
// tempo multiplier; busy stays high and no new item is taken until its result is registered.
// rst_n is asynchronous; the note table itself is not cleared (fill count guards it).
// Results cannot be stalled; done marks each item's result for one cycle.
`include "tone_table_sequencer_defines.svh"

module tone_table_sequencer #(
    parameter int TABLE_DEPTH = tts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      operation,
    input  logic [tts_pkg::FREQ_W-1:0]      note_freq,
    input  logic [tts_pkg::MS_W-1:0]        note_ms,
    output logic                            done,
    output logic                            playing,
    output logic                            note_start,
    output logic [tts_pkg::FREQ_W-1:0]      start_freq,
    output logic [tts_pkg::TIME_W-1:0]      start_ms,
    output logic                            silence,
    output logic                            table_full,
    output logic [tts_pkg::COUNT_OUT_W-1:0] stored_count,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tts_pkg::PADDR_W-1:0]     paddr,
    input  logic [tts_pkg::PDATA_W-1:0]     pwdata,
    output logic [tts_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    logic [tts_pkg::TEMPO_W-1:0] tempo_reg, tempo_next;
    logic                        repeat_reg, repeat_next;
    logic                        zigzag_reg, zigzag_next;
    logic                        cfg_wr;
    tts_pkg::reg_idx_t           reg_sel;
    tts_pkg::cfg_t               cfg;
    tts_pkg::res_t               res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = tts_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        tempo_next  = tempo_reg;
        repeat_next = repeat_reg;
        zigzag_next = zigzag_reg;
        prdata      = '0;
        case (reg_sel)
            tts_pkg::REG_TEMPO:
            begin
                prdata = tts_pkg::PDATA_W'(tempo_reg);
                if (cfg_wr)
                begin
                    tempo_next = pwdata[tts_pkg::TEMPO_W-1:0];
                end
            end
            tts_pkg::REG_REPEAT:
            begin
                prdata = tts_pkg::PDATA_W'(repeat_reg);
                if (cfg_wr)
                begin
                    repeat_next = pwdata[0];
                end
            end
            tts_pkg::REG_ZIGZAG:
            begin
                prdata = tts_pkg::PDATA_W'(zigzag_reg);
                if (cfg_wr)
                begin
                    zigzag_next = pwdata[0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg  <= tts_pkg::TEMPO_RST;
            repeat_reg <= 1'b0;
            zigzag_reg <= 1'b0;
        end
        else
        begin
            tempo_reg  <= tempo_next;
            repeat_reg <= repeat_next;
            zigzag_reg <= zigzag_next;
        end
    end

    assign cfg.tempo_q8  = tempo_reg;
    assign cfg.repeat_on = repeat_reg;
    assign cfg.zigzag_on = zigzag_reg;

    tts_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .note_freq (note_freq),
        .note_ms   (note_ms),
        .cfg       (cfg),
        .busy      (busy),
        .done      (done),
        .res       (res)
    );

    assign playing      = res.playing;
    assign note_start   = res.note_start;
    assign start_freq   = res.start_freq;
    assign start_ms     = res.start_ms;
    assign silence      = res.silence;
    assign table_full   = res.table_full;
    assign stored_count = res.stored_count;

    // non-tick items answer on the next cycle and never issue a note
    `TTS_ASSERT_NEXT(a_quick_result, start && !busy && (operation != tts_pkg::OP_TICK), done && !note_start, "non-tick item did not finish in one cycle")
    // an issued note always comes out of the multiply path
    `TTS_ASSERT_IMPLY(a_issue_after_busy, done && note_start, $past(busy) && playing, "note issued without table read and multiply")
    // refused append only when the table holds its full depth
    `TTS_ASSERT_IMPLY(a_full_count, done && table_full, stored_count == tts_pkg::COUNT_OUT_W'(TABLE_DEPTH), "table_full with table not full")

endmodule

>>> sim/tone_table_sequencer_tb.sv
`timescale 1ns / 100ps

module tone_table_sequencer_tb;

    import tts_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 115;
    localparam int SETUP_N = 10;

    // Tempo, repeat and zigzag for each random phase.
    int tempo_set[SETUP_N] = '{256, 128, 65535, 0, 384, 64, 256, 512, 1, 256};
    bit repeat_set[SETUP_N] = '{0, 1, 1, 1, 0, 1, 1, 0, 1, 1};
    bit zigzag_set[SETUP_N] = '{0, 0, 1, 1, 1, 1, 0, 0, 1, 1};

    // Mirror of the sequencer: note table, play position, timing and tempo.
    class tone_schedule;
        logic [ENTRY_W-1:0] notes [TABLE_DEPTH_DEF];
        int                 count;
        int                 position;
        bit                 fwd;
        logic [TIME_W-1:0]  elapsed;
        logic [TIME_W-1:0]  hold_ms;
        logic [TEMPO_W-1:0] tempo;
        bit                 rep;
        bit                 zz;
        res_t               due_results[$];
        int                 errors;
        int                 n_items;
        int                 n_issued;
        int                 n_refused;
        int                 n_ended;

        function new();
            count = 0;
            position = 0;
            fwd = 1'b1;
            elapsed = ELAPSED_SAT;
            hold_ms = '0;
            tempo = TEMPO_RST;
            rep = 1'b0;
            zz = 1'b0;
            errors = 0;
            n_items = 0;
            n_issued = 0;
            n_refused = 0;
            n_ended = 0;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function void set_reg(reg_idx_t idx, logic [31:0] val);
            case (idx)
                REG_TEMPO:  tempo = val[TEMPO_W-1:0];
                REG_REPEAT: rep = val[0];
                REG_ZIGZAG: zz = val[0];
                default: ;
            endcase
        endfunction

        function void advance_position();
            if (fwd)
                position++;
            else
                position--;
            if (rep && position >= count)
            begin
                if (zz)
                begin
                    position = count - ZIGZAG_BACK;
                    fwd = !fwd;
                end
                else
                begin
                    position = 0;
                end
            end
            else if (rep && position < 0)
            begin
                if (zz)
                begin
                    position = 1;
                    fwd = !fwd;
                end
                else
                begin
                    position = count - 1;
                end
            end
        endfunction

        function void take_item(op_t op, logic [FREQ_W-1:0] freq, logic [MS_W-1:0] ms);
            res_t               r;
            logic [ENTRY_W-1:0] entry;
            logic [31:0]        prod;
            r = '0;
            n_items++;
            case (op)
                OP_TICK:
                begin
                    if (elapsed != ELAPSED_SAT)
                        elapsed++;
                    r.playing = 1'b1;
                    if (elapsed > hold_ms)
                    begin
                        if (position < 0 || position >= count)
                        begin
                            r.playing = 1'b0;
                            n_ended++;
                        end
                        else
                        begin
                            entry = notes[position];
                            prod = (32'(entry[ENTRY_W-1:FREQ_W]) * 32'(tempo)) >> TEMPO_FRAC;
                            hold_ms = prod[TIME_W-1:0];
                            elapsed = '0;
                            r.note_start = 1'b1;
                            r.start_freq = entry[FREQ_W-1:0];
                            r.start_ms = hold_ms;
                            n_issued++;
                            advance_position();
                        end
                    end
                end
                OP_APPEND:
                begin
                    if (count < TABLE_DEPTH_DEF)
                    begin
                        notes[count] = {ms, freq};
                        count++;
                    end
                    else
                    begin
                        r.table_full = 1'b1;
                        n_refused++;
                    end
                end
                OP_CLEAR:
                begin
                    count = 0;
                    position = 0;
                    fwd = 1'b1;
                    elapsed = ELAPSED_SAT;
                end
                default:
                begin
                    r.silence = 1'b1;
                    position = 0;
                end
            endcase
            r.stored_count = COUNT_OUT_W'(count);
            due_results.push_back(r);
        endfunction

        task field_check(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task match_result(res_t got);
            res_t want;
            if (due_results.size() == 0)
            begin
                report_mismatch("result with no item pending");
                return;
            end
            want = due_results.pop_front();
            field_check("playing", 32'(got.playing), 32'(want.playing));
            field_check("note_start", 32'(got.note_start), 32'(want.note_start));
            field_check("start_freq", 32'(got.start_freq), 32'(want.start_freq));
            field_check("start_ms", 32'(got.start_ms), 32'(want.start_ms));
            field_check("silence", 32'(got.silence), 32'(want.silence));
            field_check("table_full", 32'(got.table_full), 32'(want.table_full));
            field_check("stored_count", 32'(got.stored_count), 32'(want.stored_count));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [1:0]             operation;
    logic [FREQ_W-1:0]      note_freq;
    logic [MS_W-1:0]        note_ms;
    logic                   done;
    logic                   playing;
    logic                   note_start;
    logic [FREQ_W-1:0]      start_freq;
    logic [TIME_W-1:0]      start_ms;
    logic                   silence;
    logic                   table_full;
    logic [COUNT_OUT_W-1:0] stored_count;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    tone_schedule sb;
    int unsigned  cycle_count;
    int           gap_pct;

    tone_table_sequencer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .note_freq    (note_freq),
        .note_ms      (note_ms),
        .done         (done),
        .playing      (playing),
        .note_start   (note_start),
        .start_freq   (start_freq),
        .start_ms     (start_ms),
        .silence      (silence),
        .table_full   (table_full),
        .stored_count (stored_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_TICK;
        note_freq = '0;
        note_ms = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycle_count = 0;
        gap_pct = 0;
        sb = new();
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tone_table_sequencer_tb failed");
            $finish;
        end
    end

    // Results cannot be held off: check whatever is marked by done.
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && done === 1'b1)
        begin
            got.playing = playing;
            got.note_start = note_start;
            got.start_freq = start_freq;
            got.start_ms = start_ms;
            got.silence = silence;
            got.table_full = table_full;
            got.stored_count = stored_count;
            sb.match_result(got);
        end
    end

    task send_item(op_t op, logic [FREQ_W-1:0] freq, logic [MS_W-1:0] ms);
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        note_freq <= freq;
        note_ms <= ms;
        do @(posedge clk); while (busy !== 1'b0);
        sb.take_item(op, freq, ms);
    endtask

    // Hold off the sender until every pending result is back.
    task drain_results();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (sb.due_results.size() > 0 && guard < 200)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
    endtask

    task write_reg(reg_idx_t idx, logic [31:0] val);
        logic [31:0] want;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
        // read back
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        want = (idx == REG_TEMPO) ? 32'(val[TEMPO_W-1:0]) : 32'(val[0]);
        if (prdata !== want)
            sb.report_mismatch($sformatf("readback reg %0d got %0h expected %0h",
                                         idx, prdata, want));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Durations kept short so playback moves; now and then a full-range one.
    function automatic logic [MS_W-1:0] pick_ms();
        int lim;
        if ($urandom_range(99) < 4)
            return MS_W'($urandom);
        lim = (sb.tempo == 0) ? 65535 : 2048 / sb.tempo;
        if (lim < 1)
            lim = 1;
        return MS_W'($urandom_range(0, lim));
    endfunction

    task run_sequence();
        int kind;
        kind = $urandom_range(99);
        if (kind < 3)
        begin
            // append 62 to 68 notes, around the table size, so some runs fill past it
            send_item(OP_CLEAR, FREQ_W'($urandom), MS_W'($urandom));
            repeat ($urandom_range(62, 68)) send_item(OP_APPEND, FREQ_W'($urandom), pick_ms());
            repeat ($urandom_range(5, 20)) send_item(OP_TICK, FREQ_W'($urandom), MS_W'($urandom));
        end
        else if (kind < 75)
        begin
            if ($urandom_range(9) != 0)
                send_item(OP_CLEAR, FREQ_W'($urandom), MS_W'($urandom));
            repeat ($urandom_range(1, 6)) send_item(OP_APPEND, FREQ_W'($urandom), pick_ms());
            repeat ($urandom_range(4, 30))
            begin
                if ($urandom_range(9) == 0)
                    send_item(OP_REWIND, FREQ_W'($urandom), MS_W'($urandom));
                else
                    send_item(OP_TICK, FREQ_W'($urandom), MS_W'($urandom));
            end
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                send_item(op_t'($urandom_range(0, 3)), FREQ_W'($urandom), MS_W'($urandom));
        end
        if ($urandom_range(29) == 0)
            drain_results();
    endtask

    initial
    begin
        int phase_end;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: default tempo, no repeat
        send_item(OP_TICK, 16'h0000, 16'h0000);     // empty table ends playback
        send_item(OP_REWIND, 16'hFFFF, 16'hFFFF);
        send_item(OP_APPEND, 16'hFFFF, 16'h0000);
        send_item(OP_APPEND, 16'h0000, 16'h0002);
        send_item(OP_APPEND, 16'h5A5A, 16'h0001);
        repeat (7) send_item(OP_TICK, 16'h0000, 16'h0000);
        send_item(OP_CLEAR, 16'h0000, 16'h0000);
        send_item(OP_TICK, 16'h0000, 16'h0000);
        drain_results();
        write_reg(REG_TEMPO, 32'h0000_FFFF);
        send_item(OP_APPEND, 16'h1234, 16'hFFFF);   // longest scaled length
        send_item(OP_TICK, 16'h0000, 16'h0000);
        send_item(OP_TICK, 16'h0000, 16'h0000);
        send_item(OP_CLEAR, 16'h0000, 16'h0000);
        drain_results();
        write_reg(REG_TEMPO, 32'h0000_0000);
        write_reg(REG_REPEAT, 32'h0000_0001);
        write_reg(REG_ZIGZAG, 32'h0000_0001);
        // one-note zigzag jumps out on both sides
        send_item(OP_APPEND, 16'h8001, 16'h0007);
        send_item(OP_TICK, 16'h0000, 16'h0000);
        send_item(OP_TICK, 16'h0000, 16'h0000);
        send_item(OP_REWIND, 16'h0000, 16'h0000);
        send_item(OP_TICK, 16'h0000, 16'h0000);
        send_item(OP_TICK, 16'h0000, 16'h0000);

        for (int ph = 0; ph < SETUP_N; ph++)
        begin
            drain_results();
            write_reg(REG_TEMPO, 32'(tempo_set[ph]));
            write_reg(REG_REPEAT, 32'(repeat_set[ph]));
            write_reg(REG_ZIGZAG, 32'(zigzag_set[ph]));
            gap_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 86 : 12);
            phase_end = sb.n_items + PHASE_ITEMS;
            while (sb.n_items < phase_end)
                run_sequence();
        end

        drain_results();
        if (sb.due_results.size() > 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.due_results.size()));

        $display("covered %0d items over %0d register settings: %0d notes issued,",
                 sb.n_items, SETUP_N + 3, sb.n_issued);
        $display("%0d appends refused on a full table, %0d ticks past the end of playback",
                 sb.n_refused, sb.n_ended);
        if (sb.errors == 0)
            $display("tone_table_sequencer_tb passed");
        else
            $display("tone_table_sequencer_tb failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/tts_pkg.sv
rtl/tts_ram.sv
rtl/tts_mul.sv
rtl/tts_core.sv
rtl/tone_table_sequencer.sv
sim/tone_table_sequencer_tb.sv
